// ===== sv/rail_slot_range_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// rail slot range allocator assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef RAIL_SLOT_RANGE_ALLOCATOR_MACROS_SVH
`define RAIL_SLOT_RANGE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define RSRA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsra assertion failed");

// next-cycle implication
`define RSRA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsra assertion failed");

`endif

// ===== sv/rsra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsra_pkg
// types, codes and constants shared by the rail slot range allocator
// ----------------------------------------------------------------------------
package rsra_pkg;

    localparam int MAP_W      = 28;
    localparam int POS_W      = 5;
    localparam int WIDTH_W    = 3;
    localparam int KEY_W      = 10;
    localparam int SLOT_OUT_W = 3;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [WIDTH_W-1:0] MIN_WIDTH_RESET = 3'd3;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_RESET = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH = 1'b1;

    // request codes
    localparam logic REQ_PLACE  = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_WIDTH = 3'd1,
        ST_NOT_FREE  = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_e;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN
    } state_e;

    typedef struct packed {
        logic               req_type;
        logic [POS_W-1:0]   rail_position;
        logic [WIDTH_W-1:0] unit_width;
        logic [KEY_W-1:0]   type_key;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [MAP_W-1:0]      occupancy_map;
    } result_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic [POS_W-1:0]   position;
        logic [KEY_W-1:0]   key;
    } slot_entry_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    scan_clear;
        logic    scan_en;
        logic    commit;
        logic    finish;
        status_e status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_remove;
        logic bad_width;
        logic not_free;
        logic hit;
        logic exhausted;
    } stat_t;

    // run of w ones, w up to 7
    function automatic logic [6:0] width_ones(input logic [WIDTH_W-1:0] w);
        logic [7:0] full;
        full = (8'd1 << w) - 8'd1;
        return full[6:0];
    endfunction

endpackage

// ===== sv/rsra_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsra_ctrl
// request sequencer: accept, check, slot scan, commit and finish
// ----------------------------------------------------------------------------
module rsra_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rsra_pkg::stat_t stat,
    output rsra_pkg::cmd_t  cmd
);
    import rsra_pkg::*;

    state_e state_reg;
    state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        busy       = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.scan_clear = 1'b1;
                priority if (!stat.is_remove && stat.bad_width)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = ST_BAD_WIDTH;
                    state_next = S_IDLE;
                end
                else if (!stat.is_remove && stat.not_free)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = ST_NOT_FREE;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                priority if (stat.hit)
                begin
                    cmd.commit = 1'b1;
                    cmd.finish = 1'b1;
                    cmd.status = ST_OK;
                    state_next = S_IDLE;
                end
                else if (stat.exhausted)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = stat.is_remove ? ST_NOT_FOUND : ST_FULL;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/rsra_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsra_datapath
// request register, occupancy map, slot table memory with valid bits,
// scan pointer and result register
// ----------------------------------------------------------------------------
`include "rail_slot_range_allocator_macros.svh"

module rsra_datapath #(
    parameter int TABLE_SLOTS = 8,
    parameter int RAIL_LENGTH = 28
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rsra_pkg::req_t                    req,
    input  logic                              cfg_we,
    input  logic [rsra_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsra_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  rsra_pkg::cmd_t                    cmd,
    output rsra_pkg::stat_t                   stat,
    output logic                              done,
    output rsra_pkg::result_t                 result
);
    import rsra_pkg::*;

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    req_t                   req_reg;
    logic [WIDTH_W-1:0]     min_width_reg;
    logic [WIDTH_W-1:0]     max_width_reg;
    logic [RAIL_LENGTH-1:0] map_reg;
    logic [RAIL_LENGTH-1:0] map_next;
    logic [TABLE_SLOTS-1:0] valid_reg;
    logic [TABLE_SLOTS-1:0] valid_next;
    slot_entry_t            slot_mem [TABLE_SLOTS];

    logic [CNT_W-1:0]       cnt_reg;
    logic [IDX_W-1:0]       issue_idx;
    logic                   issue_live;
    logic                   rd_live_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   rd_last_reg;
    slot_entry_t            rd_entry_reg;

    logic [RAIL_LENGTH-1:0] place_run;
    logic [RAIL_LENGTH-1:0] free_run;
    logic [6:0]             range_end;
    logic                   done_reg;
    result_t                result_reg;

    assign issue_idx  = cnt_reg[IDX_W-1:0];
    assign issue_live = cmd.scan_en && (cnt_reg < CNT_W'(TABLE_SLOTS));

    // positions covered by the request and by the slot under compare
    assign place_run = RAIL_LENGTH'(width_ones(req_reg.unit_width)) << req_reg.rail_position;
    assign free_run  = RAIL_LENGTH'(width_ones(rd_entry_reg.width)) << rd_entry_reg.position;
    assign range_end = 7'(req_reg.rail_position) + 7'(req_reg.unit_width);

    always_comb
    begin
        stat.is_remove = (req_reg.req_type == REQ_REMOVE);
        stat.bad_width = (req_reg.unit_width == '0) ||
                         (req_reg.unit_width < min_width_reg) ||
                         (req_reg.unit_width > max_width_reg);
        stat.not_free  = (range_end > 7'(RAIL_LENGTH)) || (|(map_reg & place_run));
        if (stat.is_remove)
        begin
            stat.hit = rd_live_reg && valid_reg[rd_idx_reg] &&
                       (rd_entry_reg.key == req_reg.type_key) &&
                       (rd_entry_reg.position == req_reg.rail_position);
        end
        else
        begin
            stat.hit = rd_live_reg && !valid_reg[rd_idx_reg];
        end
        stat.exhausted = rd_live_reg && rd_last_reg && !stat.hit;
    end

    // map and valid bits after a commit
    always_comb
    begin
        map_next   = map_reg;
        valid_next = valid_reg;
        if (cmd.commit)
        begin
            if (stat.is_remove)
            begin
                map_next               = map_reg & ~free_run;
                valid_next[rd_idx_reg] = 1'b0;
            end
            else
            begin
                map_next               = map_reg | place_run;
                valid_next[rd_idx_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_width_reg <= MIN_WIDTH_RESET;
            max_width_reg <= MAX_WIDTH_RESET;
            map_reg       <= '0;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            rd_live_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MIN_WIDTH: min_width_reg <= cfg_wdata;
                    CFG_MAX_WIDTH: max_width_reg <= cfg_wdata;
                    default:       min_width_reg <= min_width_reg;
                endcase
            end
            map_reg   <= map_next;
            valid_reg <= valid_next;
            if (cmd.scan_clear)
            begin
                cnt_reg     <= '0;
                rd_live_reg <= 1'b0;
            end
            else
            begin
                rd_live_reg <= issue_live;
                if (issue_live)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            done_reg <= cmd.finish;
        end
    end

    // payload registers and slot table
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (issue_live)
        begin
            rd_entry_reg <= slot_mem[issue_idx];
            rd_idx_reg   <= issue_idx;
            rd_last_reg  <= (issue_idx == IDX_W'(TABLE_SLOTS - 1));
        end
        if (cmd.commit && !stat.is_remove)
        begin
            slot_mem[rd_idx_reg] <= '{width:    req_reg.unit_width,
                                      position: req_reg.rail_position,
                                      key:      req_reg.type_key};
        end
        if (cmd.finish)
        begin
            result_reg.status        <= cmd.status;
            result_reg.slot_index    <= (cmd.status == ST_OK) ?
                                        SLOT_OUT_W'(rd_idx_reg) : '0;
            result_reg.occupancy_map <= MAP_W'(map_next);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `RSRA_ASSERT_NEXT(a_commit_then_done, cmd.commit, done_reg)
    `RSRA_ASSERT_NEXT(a_valid_only_on_commit, !cmd.commit, $stable(valid_reg))
    `RSRA_ASSERT_NEXT(a_place_adds_slot, cmd.commit && !stat.is_remove,
                      $countones(valid_reg) == $past($countones(valid_reg)) + 1)
    `RSRA_ASSERT_SAME(a_fail_slot_zero, done_reg && (result_reg.status != ST_OK),
                      result_reg.slot_index == '0)

endmodule

// ===== sv/rail_slot_range_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rail_slot_range_allocator
// places and removes units on a rail of positions, keeping an occupancy
// bitmap and a table of placed units
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. Its
// result is shown on result for exactly one cycle, marked by done, and the
// receiver cannot hold it off, so it must be ready to take every result.
// A place that fails its width or range check ends with done high once the
// check state has run; a request that finds its slot s ends once slot s has
// been read and compared; a place into a full table or a remove with no
// match ends after every slot has been compared. busy drops as the result
// is registered, so the next request can be taken in the cycle in which
// done is high; a new request is not taken while one is in flight. The slot
// table is a memory with one registered read port, and one slot is read
// and compared per cycle. Configuration writes take effect at once and
// should only be made while busy is low and no result is pending.
// ----------------------------------------------------------------------------
module rail_slot_range_allocator #(
    parameter int TABLE_SLOTS = 8,
    parameter int RAIL_LENGTH = 28
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              start,
    output logic                              busy,
    input  rsra_pkg::req_t                    req,
    // result channel, one cycle strobe
    output logic                              done,
    output rsra_pkg::result_t                 result,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [rsra_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsra_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import rsra_pkg::*;

    // command and status between the sequencer and the datapath
    cmd_t  cmd;
    stat_t stat;

    // sequencer: idle, check width and range, scan slots
    rsra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // datapath: map, slot table, scan pointer, result register
    rsra_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .RAIL_LENGTH (RAIL_LENGTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

endmodule
